// ----- hdl/priority_print_queue_position_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the priority print queue position block
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PRINT_QUEUE_POSITION_TOP_DEFINES_SVH
`define PRIORITY_PRINT_QUEUE_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define PPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppq assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset
`define PPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppq assertion failed");

`endif

// ----- hdl/ppq_pkg.sv -----
// ----------------------------------------------------------------------------
// ppq_pkg
// Sizes, codes and control types shared by the print queue block.
// ----------------------------------------------------------------------------
package ppq_pkg;

  localparam int MAX_JOBS        = 128;
  localparam int PRIORITY_LEVELS = 9;

  localparam int PRIO_W   = 4;
  localparam int TGT_W    = 7;
  localparam int POS_W    = 8;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int LVL_IX_W = $clog2(PRIORITY_LEVELS);
  localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIORITY_LEVELS);

  // store entry of a job that has been served; loaded priorities never read 0
  localparam logic [PRIO_W-1:0] PRIO_SERVED = '0;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET_INDEX = 1'b0;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_DONE
  } ppq_state_e;

  typedef struct packed {
    logic load;
    logic set_missing;
    logic start;
    logic eval;
    logic emit;
  } ppq_cmd_t;

  typedef struct packed {
    logic job_last;
    logic reject;
    logic hit;
    logic out_free;
  } ppq_status_t;

endpackage

// ----- hdl/ppq_job_if.sv -----
// ----------------------------------------------------------------------------
// ppq_job_if
// Job channel: one priority per item, last_job closes the batch.
// ----------------------------------------------------------------------------
interface ppq_job_if import ppq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRIO_W-1:0] priority_req;
  logic              last_job;

  modport source (output valid, output priority_req, output last_job, input ready);
  modport sink   (input valid, input priority_req, input last_job, output ready);
endinterface

// ----- hdl/ppq_result_if.sv -----
// ----------------------------------------------------------------------------
// ppq_result_if
// Result channel: service position of the target job and the missing flag.
// ----------------------------------------------------------------------------
interface ppq_result_if import ppq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] service_position;
  logic             target_missing;

  modport source (output valid, output service_position, output target_missing,
                  input ready);
  modport sink   (input valid, input service_position, input target_missing,
                  output ready);
endinterface

// ----- hdl/priority_print_queue_position_top.sv -----
// ----------------------------------------------------------------------------
// priority_print_queue_position_top
// Print queue simulation: service position of one job in a priority batch.
// ----------------------------------------------------------------------------
// Usage:
//   job_i carries one job priority per item; the item with last_job set closes
//   the batch. result_o gives one item per batch: the 1-based service position
//   of the job at arrival index target_index, or target_missing with position
//   0 when that index was not loaded or the batch overflowed the store.
//   target_index is written over the APB port at byte address 0 while idle.
// Sequence:
//   Loading accepts one job per cycle in the load state. After the closing item
//   comes a check step, then each head step is a registered read of the job
//   store followed by the serve decision against the per-level counts, and at
//   the end the result is registered. The number of head steps S is at most
//   about N*N for a batch of N jobs. A flagged batch skips the head steps.
// Reset and stall:
//   Reset clears the counts and pointers at once; no clearing pass. job_i.ready
//   stays low from the closing item until the result enters the output
//   register; while that register is full and result_o.ready is low, the
//   block holds and the next batch waits.
// ----------------------------------------------------------------------------
`include "priority_print_queue_position_top_defines.svh"

module priority_print_queue_position_top import ppq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppq_job_if.sink            job_i,
  ppq_result_if.source       result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [TGT_W-1:0] target_q;
  logic             reg_sel;
  ppq_cmd_t         cmd;
  ppq_status_t      status;
  logic             res_flagged;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TARGET_INDEX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      target_q <= pwdata[TGT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(target_q) : '0;

  ppq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_i.valid),
    .job_ready_o (job_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ppq_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .priority_req_i     (job_i.priority_req),
    .last_job_i         (job_i.last_job),
    .target_index_i     (target_q),
    .res_valid_o        (result_o.valid),
    .res_ready_i        (result_o.ready),
    .service_position_o (result_o.service_position),
    .target_missing_o   (result_o.target_missing)
  );

  assign res_flagged = result_o.valid && result_o.target_missing;

  `PPQ_ASSERT_NEXT(a_emit_shows_result, cmd.emit, result_o.valid)
  `PPQ_ASSERT_IMPL(a_missing_has_zero_pos, res_flagged, result_o.service_position == '0)
  `PPQ_ASSERT_IMPL(a_no_load_during_run, cmd.eval || cmd.start || cmd.set_missing, !job_i.ready)

endmodule

// ----- hdl/ppq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppq_ctrl
// Sequencer: load the batch, check the target, step the head, emit the item.
// ----------------------------------------------------------------------------
module ppq_ctrl import ppq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  ppq_status_t status_i,
  output ppq_cmd_t    cmd_o
);

  ppq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (job_valid_i && status_i.job_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = status_i.reject ? S_DONE : S_READ;
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = status_i.hit ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (status_i.out_free) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    job_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        job_ready_o = 1'b1;
        cmd_o.load  = job_valid_i;
      end
      S_CHECK: begin
        cmd_o.set_missing = status_i.reject;
        cmd_o.start       = !status_i.reject;
      end
      S_READ: begin
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      S_DONE: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/ppq_datapath.sv -----
// ----------------------------------------------------------------------------
// ppq_datapath
// Job store with served marks, per-level counts, head pointer and result register.
// ----------------------------------------------------------------------------
module ppq_datapath import ppq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppq_cmd_t          cmd_i,
  output ppq_status_t       status_o,
  input  logic [PRIO_W-1:0] priority_req_i,
  input  logic              last_job_i,
  input  logic [TGT_W-1:0]  target_index_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [POS_W-1:0]  service_position_o,
  output logic              target_missing_o
);

  logic [PRIO_W-1:0] store_mem [MAX_JOBS];
  logic [PRIO_W-1:0] rd_q;

  logic [CNT_W-1:0]    counts_q [PRIORITY_LEVELS];
  logic [IDX_W-1:0]    head_q;
  logic [CNT_W-1:0]    srv_q;
  logic [CNT_W-1:0]    loaded_q;
  logic                ovf_q;
  logic [POS_W-1:0]    pos_q;
  logic                missing_q;
  logic                out_valid_q;
  logic [POS_W-1:0]    out_pos_q;
  logic                out_missing_q;

  logic [PRIO_W-1:0]   prio_clamped;
  logic                room;
  logic                higher;
  logic                serve;
  logic                hit;
  logic [CNT_W-1:0]    head_inc;
  logic [IDX_W-1:0]    head_next;
  logic [WIDE_W-1:0]   pos_next;
  logic [LVL_IX_W-1:0] in_lvl;
  logic [LVL_IX_W-1:0] rd_lvl;

  always_comb begin
    prio_clamped = priority_req_i;
    if (priority_req_i < PRIO_MIN) prio_clamped = PRIO_MIN;
    if (priority_req_i > PRIO_MAX) prio_clamped = PRIO_MAX;
  end

  assign room   = (loaded_q < CNT_W'(MAX_JOBS));
  assign in_lvl = LVL_IX_W'(prio_clamped - PRIO_MIN);
  assign rd_lvl = LVL_IX_W'(rd_q - PRIO_MIN);

  // any waiting job at a strictly higher level than the head job
  always_comb begin
    higher = 1'b0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if ((l + 1) > int'(rd_q) && counts_q[l] != '0) higher = 1'b1;
    end
  end

  assign serve     = (rd_q != PRIO_SERVED) && !higher;
  assign hit       = serve && (WIDE_W'(head_q) == WIDE_W'(target_index_i));
  assign head_inc  = CNT_W'(head_q) + CNT_W'(1);
  assign head_next = (head_inc >= loaded_q) ? '0 : IDX_W'(head_inc);
  assign pos_next  = WIDE_W'(srv_q) + WIDE_W'(1);

  assign status_o.job_last = last_job_i;
  assign status_o.reject   = ovf_q || (WIDE_W'(target_index_i) >= WIDE_W'(loaded_q));
  assign status_o.hit      = cmd_i.eval && hit;
  assign status_o.out_free = !out_valid_q || res_ready_i;

  // job store: write on load, mark the head served, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      store_mem[loaded_q[IDX_W-1:0]] <= prio_clamped;
    end else if (cmd_i.eval && serve) begin
      store_mem[head_q] <= PRIO_SERVED;
    end
    rd_q <= store_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) counts_q[l] <= '0;
      head_q   <= '0;
      srv_q    <= '0;
      loaded_q <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.emit) begin
      // clear the batch once the result is registered
      for (int l = 0; l < PRIORITY_LEVELS; l++) counts_q[l] <= '0;
      head_q   <= '0;
      srv_q    <= '0;
      loaded_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (room) begin
          counts_q[in_lvl] <= counts_q[in_lvl] + CNT_W'(1);
          loaded_q         <= loaded_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.start) head_q <= '0;
      if (cmd_i.eval) begin
        if (serve) begin
          counts_q[rd_lvl] <= counts_q[rd_lvl] - CNT_W'(1);
          srv_q            <= srv_q + CNT_W'(1);
        end
        head_q <= head_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_missing) begin
      pos_q     <= '0;
      missing_q <= 1'b1;
    end else if (cmd_i.start) begin
      missing_q <= 1'b0;
    end else if (cmd_i.eval && hit) begin
      pos_q <= pos_next[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pos_q     <= pos_q;
      out_missing_q <= missing_q;
    end
  end

  assign res_valid_o        = out_valid_q;
  assign service_position_o = out_pos_q;
  assign target_missing_o   = out_missing_q;

endmodule
